FILE: hw/rtl/set_assoc_lru_cache_stats_defines.svh
// assertion macros for the cache statistics block
// used by the top level only, no other dependencies
`ifndef SET_ASSOC_LRU_CACHE_STATS_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_STATS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on clk_i, off while rst_ni is low
`define SLCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on clk_i at every edge, reset included
`define SLCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SLCS_ASSERT(lbl, prop, msg)
`define SLCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/slcs_pkg.sv
// shared constants, types and helpers of the cache statistics block
// no dependencies
package slcs_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ADDR_IN_W   = 64;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned SET_BITS_W  = 3;
  localparam int unsigned OFF_BITS_W  = 6;
  localparam int unsigned WAYS_USED_W = 4;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SHIFT_W     = 7;

  // access kinds
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd2;

  localparam logic [SET_BITS_W-1:0]  SET_BITS_RST  = 3'd4;
  localparam logic [OFF_BITS_W-1:0]  OFF_BITS_RST  = 6'd4;
  localparam logic [WAYS_USED_W-1:0] WAYS_USED_RST = 4'd1;

  typedef struct packed {
    logic en;
    logic first;
  } scan_ctrl_t;

  typedef struct packed {
    logic hit;
    logic has_free;
  } scan_flags_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hw/rtl/slcs_if.sv
// valid/ready channel interfaces for access words and result words
// depends on slcs_pkg
interface slcs_in_if;
  logic                              valid;
  logic                              ready;
  logic [slcs_pkg::CMD_W-1:0]        cmd;
  logic [slcs_pkg::ADDR_IN_W-1:0]    address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface slcs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         miss;
  logic                         evicted;
  logic [slcs_pkg::CNT_W-1:0]   hit_total;
  logic [slcs_pkg::CNT_W-1:0]   miss_total;
  logic [slcs_pkg::CNT_W-1:0]   evict_total;
  logic                         last;

  modport source (output valid, output hit, output miss, output evicted,
                  output hit_total, output miss_total, output evict_total,
                  output last, input ready);
  modport sink   (input valid, input hit, input miss, input evicted,
                  input hit_total, input miss_total, input evict_total,
                  input last, output ready);
endinterface

FILE: hw/rtl/slcs_set_ram.sv
// set memory: one row holds every way of a set, registered read
// no dependencies
module slcs_set_ram #(
  parameter int unsigned ROW_W  = 528,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ROW_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [ROW_W-1:0]  rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/slcs_way_scan.sv
// shared way compare unit: when enabled, looks at one way per cycle
// and keeps the hit, first free and oldest way; depends on slcs_pkg
module slcs_way_scan #(
  parameter int unsigned MAX_WAYS = 8,
  parameter int unsigned TAG_W    = 62,
  parameter int unsigned RANK_W   = 3,
  parameter int unsigned WAY_W    = 3
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  slcs_pkg::scan_ctrl_t                   ctrl_i,
  input  logic [MAX_WAYS-1:0][TAG_W+RANK_W:0]    row_i,
  input  logic [WAY_W-1:0]                       way_i,
  input  logic [TAG_W-1:0]                       tag_i,
  output slcs_pkg::scan_flags_t                  flags_o,
  output logic [WAY_W-1:0]                       hit_way_o,
  output logic [RANK_W-1:0]                      hit_rank_o,
  output logic [WAY_W-1:0]                       free_way_o,
  output logic [WAY_W-1:0]                       vic_way_o,
  output logic [RANK_W-1:0]                      vic_rank_o
);

  localparam int unsigned ENT_W = TAG_W + RANK_W + 1;

  logic [ENT_W-1:0]  ent;
  logic              ent_valid;
  logic [RANK_W-1:0] ent_rank;
  logic              tag_eq;

  slcs_pkg::scan_flags_t flags_q;
  logic [WAY_W-1:0]      hit_way_q, free_way_q, vic_way_q;
  logic [RANK_W-1:0]     hit_rank_q, vic_rank_q;

  assign ent       = row_i[way_i];
  assign ent_valid = ent[ENT_W-1];
  assign ent_rank  = ent[TAG_W +: RANK_W];
  assign tag_eq    = (ent[TAG_W-1:0] == tag_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ctrl_i.en) begin
      if (ctrl_i.first) begin
        flags_q.hit      <= ent_valid && tag_eq;
        flags_q.has_free <= !ent_valid;
      end else begin
        if (ent_valid && tag_eq) flags_q.hit <= 1'b1;
        if (!ent_valid) flags_q.has_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      if (ctrl_i.first) begin
        hit_way_q  <= way_i;
        hit_rank_q <= ent_rank;
        free_way_q <= way_i;
        vic_way_q  <= way_i;
        vic_rank_q <= ent_rank;
      end else begin
        // first match wins
        if (!flags_q.hit && ent_valid && tag_eq) begin
          hit_way_q  <= way_i;
          hit_rank_q <= ent_rank;
        end
        if (!flags_q.has_free && !ent_valid) free_way_q <= way_i;
        // strictly older only, so ties keep the lower way
        if (ent_rank > vic_rank_q) begin
          vic_way_q  <= way_i;
          vic_rank_q <= ent_rank;
        end
      end
    end
  end

  assign flags_o    = flags_q;
  assign hit_way_o  = hit_way_q;
  assign hit_rank_o = hit_rank_q;
  assign free_way_o = free_way_q;
  assign vic_way_o  = vic_way_q;
  assign vic_rank_o = vic_rank_q;

endmodule

FILE: hw/rtl/slcs_row_update.sv
// new set row after an access: on a miss fill the chosen way, make it newest
// and age the younger valid ways; no dependencies
module slcs_row_update #(
  parameter int unsigned MAX_WAYS = 8,
  parameter int unsigned TAG_W    = 62,
  parameter int unsigned RANK_W   = 3,
  parameter int unsigned WAY_W    = 3,
  parameter int unsigned WC_W     = 4
) (
  input  logic [MAX_WAYS-1:0][TAG_W+RANK_W:0] row_i,
  input  logic [WC_W-1:0]                     ways_i,
  input  logic [WAY_W-1:0]                    way_i,
  input  logic [RANK_W:0]                     rank_i,
  input  logic                                fill_i,
  input  logic [TAG_W-1:0]                    tag_i,
  output logic [MAX_WAYS-1:0][TAG_W+RANK_W:0] row_o
);

  localparam int unsigned ENT_W = TAG_W + RANK_W + 1;
  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);

  always_comb begin
    logic              vld;
    logic [RANK_W-1:0] rk;
    logic [TAG_W-1:0]  tg;
    for (int j = 0; j < MAX_WAYS; j++) begin
      vld = row_i[j][ENT_W-1];
      rk  = row_i[j][TAG_W +: RANK_W];
      tg  = row_i[j][TAG_W-1:0];
      if (WC_W'(j) < ways_i) begin
        if (WAY_W'(j) == way_i) begin
          rk = '0;
          if (fill_i) begin
            vld = 1'b1;
            tg  = tag_i;
          end
        end else if (vld && ({1'b0, rk} < rank_i) && (rk < RANK_TOP)) begin
          rk = rk + 1'b1;
        end
      end
      row_o[j] = {vld, rk, tg};
    end
  end

endmodule

FILE: hw/rtl/set_assoc_lru_cache_stats.sv
// top level of the tag-only set-associative cache with lru statistics
// depends on slcs_pkg, slcs_if, slcs_set_ram, slcs_way_scan, slcs_row_update
//
// usage
//   in_i carries access words (cmd, address); out_o carries result words
//   (hit, miss, evicted, running totals, last). both are valid/ready.
//   cmd load or store gives one result word, modify gives two (last set
//   on the second), the unused code is taken and dropped.
//   the user writes the configuration through cfg_we_i/cfg_idx_i/cfg_data_i
//   only while idle, not enforced by the block; unknown indexes are ignored.
// sequence
//   one access is a row read, a compare of each way in use in turn, and a
//   row write. a word is one accept plus one access (load, store) or two
//   (modify). ways are compared one at a time by the per-way compare unit,
//   and the block takes no new word until the last is done: in_i.ready is
//   high only between words.
// reset
//   counters clear and registers take their reset values; then a clearing
//   pass writes every set row to zero, all 2^MAX_SET_BITS of them (64 by
//   default), with in_i.ready low.
// stalls
//   the result sits in an output register; the write step of the next
//   access waits while that register is still full and not being taken.
`include "set_assoc_lru_cache_stats_defines.svh"

module set_assoc_lru_cache_stats #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_WIDTH   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [slcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [slcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  slcs_in_if.sink                           in_i,
  slcs_out_if.source                        out_o
);

  localparam int unsigned SET_W  = MAX_SET_BITS;
  localparam int unsigned TAG_W  = ADDR_WIDTH - 2;
  localparam int unsigned RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WAY_W  = RANK_W;
  localparam int unsigned WC_W   = $clog2(MAX_WAYS + 1);
  localparam int unsigned ENT_W  = TAG_W + RANK_W + 1;
  localparam int unsigned ROW_W  = MAX_WAYS * ENT_W;
  localparam int unsigned CW     = slcs_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [slcs_pkg::SET_BITS_W-1:0]  set_bits_q;
  logic [slcs_pkg::OFF_BITS_W-1:0]  offset_bits_q;
  logic [slcs_pkg::WAYS_USED_W-1:0] ways_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= slcs_pkg::SET_BITS_RST;
      offset_bits_q <= slcs_pkg::OFF_BITS_RST;
      ways_used_q   <= slcs_pkg::WAYS_USED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slcs_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data_i[slcs_pkg::SET_BITS_W-1:0];
        slcs_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[slcs_pkg::OFF_BITS_W-1:0];
        slcs_pkg::CFG_WAYS_USED:   ways_used_q   <= cfg_data_i[slcs_pkg::WAYS_USED_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [slcs_pkg::SET_BITS_W-1:0] sb_eff;
  logic [WC_W-1:0]                 ways_eff;
  logic [WAY_W-1:0]                last_way;

  assign sb_eff = (32'(set_bits_q) > MAX_SET_BITS) ?
                  slcs_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits_q;

  always_comb begin
    if (ways_used_q == '0) begin
      ways_eff = WC_W'(1);
    end else if (32'(ways_used_q) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_used_q);
    end
  end

  assign last_way = WAY_W'(ways_eff - 1'b1);

  // address split at accept
  logic [ADDR_WIDTH-1:0]             addr_m, set_full, tag_full;
  logic [SET_W-1:0]                  set_mask, set_idx;
  logic [slcs_pkg::SHIFT_W-1:0]      tag_sh;

  assign addr_m   = in_i.address[ADDR_WIDTH-1:0];
  assign set_full = addr_m >> offset_bits_q;
  assign set_mask = ~({SET_W{1'b1}} << sb_eff);
  assign set_idx  = set_full[SET_W-1:0] & set_mask;
  // shifts of the full width or more leave a zero tag
  assign tag_sh   = {1'b0, offset_bits_q} + slcs_pkg::SHIFT_W'(sb_eff);
  assign tag_full = addr_m >> tag_sh;

  logic             in_acc, cmd_ok;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             two_q, pass_q, pass_d;
  logic [WAY_W-1:0] way_q, way_d;
  logic [SET_W-1:0] clr_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cmd_ok     = (in_i.cmd == slcs_pkg::CMD_LOAD) || (in_i.cmd == slcs_pkg::CMD_STORE) ||
                      (in_i.cmd == slcs_pkg::CMD_MODIFY);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q <= set_idx;
      tag_q <= tag_full[TAG_W-1:0];
      two_q <= (in_i.cmd == slcs_pkg::CMD_MODIFY);
    end
  end

  // set memory and the shared compare unit
  logic [MAX_WAYS-1:0][ENT_W-1:0] row_rd, row_wr;
  logic                           ram_we, ram_re;
  logic [SET_W-1:0]               ram_waddr;
  logic [ROW_W-1:0]               ram_wdata, ram_rdata;

  assign ram_re    = (state_q == S_READ);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : set_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : row_wr;
  assign row_rd    = ram_rdata;

  slcs_set_ram #(
    .ROW_W  (ROW_W),
    .ADDR_W (SET_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_q),
    .rdata_o (ram_rdata)
  );

  slcs_pkg::scan_ctrl_t  scan_ctrl;
  slcs_pkg::scan_flags_t scan_flags;
  logic [WAY_W-1:0]      hit_way, free_way, vic_way;
  logic [RANK_W-1:0]     hit_rank, vic_rank;

  assign scan_ctrl.en    = (state_q == S_SCAN);
  assign scan_ctrl.first = (way_q == '0);

  slcs_way_scan #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .RANK_W   (RANK_W),
    .WAY_W    (WAY_W)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .row_i      (row_rd),
    .way_i      (way_q),
    .tag_i      (tag_q),
    .flags_o    (scan_flags),
    .hit_way_o  (hit_way),
    .hit_rank_o (hit_rank),
    .free_way_o (free_way),
    .vic_way_o  (vic_way),
    .vic_rank_o (vic_rank)
  );

  // replacement choice from the scan
  logic              acc_hit, acc_evict;
  logic [WAY_W-1:0]  tgt_way;
  logic [RANK_W:0]   tgt_rank;

  assign acc_hit   = scan_flags.hit;
  assign acc_evict = !scan_flags.hit && !scan_flags.has_free;
  assign tgt_way   = scan_flags.hit ? hit_way : (scan_flags.has_free ? free_way : vic_way);
  // a fill into a free way ages every valid way in use below the top rank
  assign tgt_rank  = scan_flags.hit      ? {1'b0, hit_rank} :
                     scan_flags.has_free ? (RANK_W + 1)'(MAX_WAYS) : {1'b0, vic_rank};

  slcs_row_update #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .RANK_W   (RANK_W),
    .WAY_W    (WAY_W),
    .WC_W     (WC_W)
  ) u_update (
    .row_i  (row_rd),
    .ways_i (ways_eff),
    .way_i  (tgt_way),
    .rank_i (tgt_rank),
    .fill_i (!acc_hit),
    .tag_i  (tag_q),
    .row_o  (row_wr)
  );

  // output register and counters
  logic          out_valid_q, out_free, commit;
  logic          out_hit_q, out_miss_q, out_evict_q, out_last_q;
  logic [CW-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [CW-1:0] hit_cnt_d, miss_cnt_d, evict_cnt_d;

  assign out_free = !out_valid_q || out_o.ready;
  assign commit   = (state_q == S_WRITE) && out_free;
  assign ram_we   = (state_q == S_CLEAR) || commit;

  assign hit_cnt_d   = acc_hit   ? slcs_pkg::sat_inc(hit_cnt_q)   : hit_cnt_q;
  assign miss_cnt_d  = !acc_hit  ? slcs_pkg::sat_inc(miss_cnt_q)  : miss_cnt_q;
  assign evict_cnt_d = acc_evict ? slcs_pkg::sat_inc(evict_cnt_q) : evict_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_hit_q   <= acc_hit;
      out_miss_q  <= !acc_hit;
      out_evict_q <= acc_evict;
      out_last_q  <= !two_q || pass_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.miss        = out_miss_q;
  assign out_o.evicted     = out_evict_q;
  assign out_o.hit_total   = hit_cnt_q;
  assign out_o.miss_total  = miss_cnt_q;
  assign out_o.evict_total = evict_cnt_q;
  assign out_o.last        = out_last_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    way_d   = way_q;
    pass_d  = pass_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == {SET_W{1'b1}}) state_d = S_IDLE;
      end
      S_IDLE: begin
        // the unused code is taken and dropped here
        if (in_acc && cmd_ok) begin
          state_d = S_READ;
          pass_d  = 1'b0;
        end
      end
      S_READ: begin
        state_d = S_SCAN;
        way_d   = '0;
      end
      S_SCAN: begin
        if (way_q == last_way) begin
          state_d = S_WRITE;
        end else begin
          way_d = way_q + 1'b1;
        end
      end
      S_WRITE: begin
        if (commit) begin
          if (two_q && !pass_q) begin
            // second access of a modify re-reads the row just written
            state_d = S_READ;
            pass_d  = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      way_q   <= '0;
      pass_q  <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      way_q   <= way_d;
      pass_q  <= pass_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // checks
  `SLCS_ASSERT(a_scan_in_range, (state_q == S_SCAN) |-> (way_q <= last_way), "way scan ran past the ways in use")
  `SLCS_ASSERT(a_flags_consistent, out_valid_q |-> ((out_hit_q ^ out_miss_q) && (!out_evict_q || out_miss_q)), "result flags inconsistent")
  `SLCS_ASSERT(a_hit_cnt_monotone, 1'b1 |=> (hit_cnt_q >= $past(hit_cnt_q)), "hit count went down")
  `SLCS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_o.valid, "result valid during reset")

endmodule
